### hdl/skl_pkg.sv
`default_nettype none

package skl_pkg;

  // Sequencer states of the lookup-or-create engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } skl_state_t;

  // Status handed from the slot scanner to the sequencer.
  typedef struct packed {
    logic done;
    logic hit;
    logic have_free;
  } skl_scan_stat_t;

  localparam int USERS_BITS = 8;
  localparam logic [USERS_BITS-1:0] USERS_MAX = 8'd255;
  localparam logic [USERS_BITS-1:0] USERS_FIRST = 8'd1;

endpackage

`default_nettype wire

### hdl/semaphore_key_lookup_or_create_top.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_ready    request_key, process_number
// result    out        out_valid / out_ready  success, slot_index, newly_created
//
// A request scans every slot when no active slot holds its key, and stops
// early when a match turns up; the single key comparator steps one slot per
// cycle through the key memory.
// Reset clears the slot active bits and the membership row valid bits at once.
// A finished result waits in the output register while the next request is
// accepted; the engine stalls only if a second result is ready before then.

module semaphore_key_lookup_or_create_top
  import skl_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int PROCESS_COUNT = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] request_key,
  input  wire logic [5:0]  process_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             success,
  output logic [5:0]       slot_index,
  output logic             newly_created
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PROC_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;

  skl_state_t state, state_next;

  // Request registers, loaded when a request is accepted.
  logic [KEY_BITS-1:0] req_key;
  logic [PROC_W-1:0]   req_proc;
  logic                req_proc_ok;

  // Outcome of the current request.
  logic [SLOT_W-1:0]   slot;
  logic                create;
  logic                res_success;

  // The active bits and membership row valid bits live in flip-flops so that
  // reset can clear them all together.
  logic [SLOT_COUNT-1:0]    slot_active;
  logic [PROCESS_COUNT-1:0] row_valid;

  logic                in_fire;
  logic                out_free;
  logic [63:0]         key_ext;
  logic [8:0]          proc_ext;

  logic                   scan_start;
  logic [SLOT_W-1:0]      scan_addr;
  logic [SLOT_W-1:0]      scan_idx;
  skl_scan_stat_t         scan_stat;
  logic [KEY_BITS-1:0]    key_q;

  logic [USERS_BITS-1:0]  users_q;
  logic [USERS_BITS-1:0]  users_next;
  logic [SLOT_COUNT-1:0]  row_q;
  logic [SLOT_COUNT-1:0]  row_next;
  logic                   wr_phase;
  logic                   key_wr;
  logic                   row_wr;
  logic [7:0]             slot_ext;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Only the low KEY_BITS of the request key take part in the lookup.
  assign key_ext  = {32'd0, request_key};
  assign proc_ext = 9'(process_number);

  assign scan_start = in_fire;

  skl_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS),
    .SLOT_W     (SLOT_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .key     (req_key),
    .active  (slot_active),
    .rd_key  (key_q),
    .rd_addr (scan_addr),
    .res_idx (scan_idx),
    .stat    (scan_stat)
  );

  // Stored keys; read by the scanner, written when a slot is claimed.
  assign wr_phase = (state == ST_WRITE);
  assign key_wr   = wr_phase && create;

  skl_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (KEY_BITS),
    .AW    (SLOT_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (slot),
    .wr_data (req_key),
    .rd_addr (scan_addr),
    .rd_data (key_q)
  );

  // User counts per slot, read in the read phase and written back once.
  // A freshly claimed slot starts from zero, so its first count is one.
  always_comb begin
    if (create) begin
      users_next = USERS_FIRST;
    end else if (users_q == USERS_MAX) begin
      users_next = USERS_MAX;
    end else begin
      users_next = users_q + USERS_BITS'(1);
    end
  end

  skl_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (USERS_BITS),
    .AW    (SLOT_W)
  ) u_users_ram (
    .clk     (clk),
    .wr_en   (wr_phase),
    .wr_addr (slot),
    .wr_data (users_next),
    .rd_addr (slot),
    .rd_data (users_q)
  );

  // Membership bitmaps, one row per process. A row never written reads as
  // zero through its valid bit.
  assign row_wr   = wr_phase && req_proc_ok;
  assign row_next = (row_valid[req_proc] ? row_q : '0) | (SLOT_COUNT'(1) << slot);

  skl_ram #(
    .DEPTH (PROCESS_COUNT),
    .WIDTH (SLOT_COUNT),
    .AW    (PROC_W)
  ) u_member_ram (
    .clk     (clk),
    .wr_en   (row_wr),
    .wr_addr (req_proc),
    .wr_data (row_next),
    .rd_addr (req_proc),
    .rd_data (row_q)
  );

  // Sequencer: scan, read the slot's count and process row, write back, then
  // hand the result to the output register; a failed scan skips read and write.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.hit || scan_stat.have_free) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and the outcome of the scan.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_key     <= key_ext[KEY_BITS-1:0];
      req_proc    <= proc_ext[PROC_W-1:0];
      req_proc_ok <= (proc_ext < 9'(PROCESS_COUNT));
    end
    if (state == ST_SCAN && scan_stat.done) begin
      slot        <= scan_idx;
      create      <= !scan_stat.hit && scan_stat.have_free;
      res_success <= scan_stat.hit || scan_stat.have_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      row_valid   <= '0;
    end else if (wr_phase) begin
      if (create) begin
        slot_active[slot] <= 1'b1;
      end
      if (req_proc_ok) begin
        row_valid[req_proc] <= 1'b1;
      end
    end
  end

  // Output register. A failed request reports slot zero and no creation.
  assign slot_ext = 8'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      success       <= res_success;
      slot_index    <= res_success ? slot_ext[5:0] : 6'd0;
      newly_created <= res_success && create;
    end
  end

  // The scanner only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> state == ST_SCAN)
    else $error("scan finished outside the scan phase");

  // A successful result always names a slot that is active by then.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && res_success) |-> slot_active[slot])
    else $error("result slot is not active");

  // A request only fails when every slot is taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !res_success) |-> &slot_active)
    else $error("request failed with a free slot left");

endmodule

`default_nettype wire

### hdl/skl_ram.sv
`default_nettype none

module skl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/skl_scan.sv
`default_nettype none

module skl_scan
  import skl_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int KEY_BITS = 32,
  parameter int SLOT_W = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [SLOT_COUNT-1:0] active,
  input  wire logic [KEY_BITS-1:0]   rd_key,
  output logic      [SLOT_W-1:0]     rd_addr,
  output logic      [SLOT_W-1:0]     res_idx,
  output skl_scan_stat_t             stat
);

  logic              busy;
  logic [SLOT_W:0]   issue_cnt;
  logic              cmp_valid;
  logic [SLOT_W-1:0] cmp_idx;
  logic              hit;
  logic              have_free;
  logic              done;
  logic              match;
  logic              last;

  assign rd_addr = issue_cnt[SLOT_W-1:0];
  assign match   = active[cmp_idx] && (rd_key == key);
  assign last    = (cmp_idx == SLOT_W'(SLOT_COUNT - 1));

  // One key compare per cycle; each key is read in the cycle before its compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue_cnt <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      done      <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      issue_cnt <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      done      <= 1'b0;
    end else if (busy && cmp_valid && (match || last)) begin
      // The first matching slot or the last slot ends the scan.
      busy      <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b1;
      if (match) begin
        hit     <= 1'b1;
        res_idx <= cmp_idx;
      end else if (!active[cmp_idx] && !have_free) begin
        have_free <= 1'b1;
        res_idx   <= cmp_idx;
      end
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (issue_cnt < (SLOT_W + 1)'(SLOT_COUNT)) begin
          cmp_valid <= 1'b1;
          cmp_idx   <= rd_addr;
          issue_cnt <= issue_cnt + (SLOT_W + 1)'(1);
        end else begin
          cmp_valid <= 1'b0;
        end
        if (cmp_valid && !active[cmp_idx] && !have_free) begin
          have_free <= 1'b1;
          res_idx   <= cmp_idx;
        end
      end
    end
  end

  assign stat = '{done: done, hit: hit, have_free: have_free};

endmodule

`default_nettype wire

### verif/semaphore_key_lookup_or_create_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the semaphore key lookup-or-create engine.
// Requests go in on a valid/ready channel and every request yields exactly one
// result. A scoreboard in this module tracks the slot table the way the engine
// should, so each accepted request pushes the result it must produce. The
// result side pops and compares in order.
module semaphore_key_lookup_or_create_top_test
  import skl_pkg::*;
();

  localparam int SLOT_COUNT = 64;
  localparam int PROCESS_COUNT = 64;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int KEY_POOL_SIZE = 96;
  // A full scan of the table plus the update and output cycles, with margin.
  localparam int DRAIN_CYCLES = SLOT_COUNT + 16;
  // The slowest correct run is 1720 requests, each scanning the whole table, plus
  // sender gaps and result stalls. The limit is set well above that.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_COUNT = 20;

  typedef struct packed {
    logic       success;
    logic [5:0] slot_index;
    logic       newly_created;
  } lookup_result_t;

  // One line of the directed table. Where has_typed is set, the result is
  // written out by hand; otherwise the scoreboard supplies it.
  typedef struct packed {
    logic [31:0]    key;
    logic [5:0]     proc;
    logic           has_typed;
    lookup_result_t result;
  } directed_row_t;

  // The first rows start from an empty table, so every slot number is obvious:
  // keys claim slots in order and repeats land on the slot they claimed before.
  // The rest of the rows mix key bit patterns and are checked by the scoreboard.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{32'h0000_0000, 6'd0,  1'b1, '{1'b1, 6'd0, 1'b1}},
    '{32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b1, 6'd1, 1'b1}},
    '{32'h0000_0000, 6'd63, 1'b1, '{1'b1, 6'd0, 1'b0}},
    '{32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 6'd1, 1'b0}},
    '{32'h8000_0000, 6'd21, 1'b1, '{1'b1, 6'd2, 1'b1}},
    '{32'h0000_0001, 6'd42, 1'b1, '{1'b1, 6'd3, 1'b1}},
    '{32'h7FFF_FFFF, 6'd1,  1'b1, '{1'b1, 6'd4, 1'b1}},
    '{32'hFFFF_FFFE, 6'd62, 1'b1, '{1'b1, 6'd5, 1'b1}},
    '{32'h0000_0000, 6'd32, 1'b1, '{1'b1, 6'd0, 1'b0}},
    '{32'h8000_0000, 6'd21, 1'b1, '{1'b1, 6'd2, 1'b0}},
    '{32'hAAAA_AAAA, 6'd5,  1'b0, '0},
    '{32'h5555_5555, 6'd10, 1'b0, '0},
    '{32'h1234_5678, 6'd31, 1'b0, '0},
    '{32'h0001_0000, 6'd16, 1'b0, '0},
    '{32'h0000_FFFF, 6'd48, 1'b0, '0},
    '{32'hFFFF_0000, 6'd7,  1'b0, '0},
    '{32'h7FFF_FFFF, 6'd8,  1'b0, '0},
    '{32'hAAAA_AAAA, 6'd5,  1'b0, '0},
    '{32'hC3C3_C3C3, 6'd56, 1'b0, '0},
    '{32'h0000_0001, 6'd63, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] request_key = '0;
  logic [5:0]  process_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        success;
  logic [5:0]  slot_index;
  logic        newly_created;

  // Scoreboard copy of the slot table. Value and priority never show at the
  // outputs, so only the fields that steer the lookup are tracked, along with
  // the user counts and membership bits the engine updates.
  bit                    slot_in_use [SLOT_COUNT];
  logic [31:0]           slot_key_copy [SLOT_COUNT];
  logic [USERS_BITS-1:0] slot_user_count [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] membership_rows [PROCESS_COUNT];

  lookup_result_t expected_results [$];
  logic [31:0]    key_pool [KEY_POOL_SIZE];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  int             mode_left = 0;

  semaphore_key_lookup_or_create_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .request_key    (request_key),
    .process_number (process_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .success        (success),
    .slot_index     (slot_index),
    .newly_created  (newly_created)
  );

  always #5 clk = ~clk;

  // Look for the first active slot with this key; failing that, claim the lowest
  // free slot. The table update and the result come out together, in the order
  // the requests are accepted.
  function automatic lookup_result_t find_or_claim_slot(input logic [31:0] key,
                                                        input logic [5:0] proc);
    lookup_result_t res;
    int slot;
    bit hit;
    res = '0;
    slot = -1;
    hit = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot < 0 && slot_in_use[i] && slot_key_copy[i] == key) begin
        slot = i;
        hit = 1'b1;
      end
    end
    if (slot < 0) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot < 0 && !slot_in_use[i]) begin
          slot = i;
        end
      end
    end
    // With every slot taken and no key match, the table is full and nothing moves.
    if (slot >= 0) begin
      if (!hit) begin
        slot_in_use[slot] = 1'b1;
        slot_key_copy[slot] = key;
        slot_user_count[slot] = '0;
      end
      if (int'(proc) < PROCESS_COUNT) begin
        membership_rows[proc][slot] = 1'b1;
      end
      // The user count sticks at its maximum instead of wrapping.
      if (slot_user_count[slot] < USERS_MAX) begin
        slot_user_count[slot] = slot_user_count[slot] + USERS_BITS'(1);
      end
      res.success = 1'b1;
      res.slot_index = slot[5:0];
      res.newly_created = !hit;
    end
    return res;
  endfunction

  // Random keys mostly come from a fixed pool whose reachable part grows over
  // the run, so the table fills gradually and matches show up at every depth of
  // the scan. One hot key is hammered hard enough to drive its user count into
  // saturation, and a few fresh keys add noise that mostly fails once the
  // table is full.
  function automatic logic [31:0] choose_key(input int item);
    int pick;
    int reach;
    pick = $urandom_range(0, 99);
    reach = 4 + item / 12;
    if (reach > KEY_POOL_SIZE - 1) begin
      reach = KEY_POOL_SIZE - 1;
    end
    if (pick < 20) begin
      return key_pool[0];
    end else if (pick < 23) begin
      return $urandom;
    end
    return key_pool[$urandom_range(0, reach)];
  endfunction

  function automatic void log_mismatch(input string what, input lookup_result_t want,
                                       input lookup_result_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected success=%0b slot=%0d new=%0b, got success=%0b slot=%0d new=%0b",
               $realtime, what, want.success, want.slot_index, want.newly_created,
               seen.success, seen.slot_index, seen.newly_created);
    end
  endfunction

  // Present one request and hold it until accepted. The payload goes out on the
  // current edge, and the handshake is sampled at each later edge. valid is left
  // high afterward, so back-to-back requests never drop it for a step.
  task automatic send_request(input logic [31:0] key, input logic [5:0] proc,
                              input bit has_typed, input lookup_result_t typed_result);
    lookup_result_t predicted;
    in_valid <= 1'b1;
    request_key <= key;
    process_number <= proc;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = find_or_claim_slot(key, proc);
    expected_results.push_back(has_typed ? typed_result : predicted);
  endtask

  // The sender works in bursts. When a burst runs out it usually goes quiet for
  // a random gap, but not always, which leaves runs of back-to-back requests.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_in_use[i] = 1'b0;
    end
    for (int p = 0; p < PROCESS_COUNT; p++) begin
      membership_rows[p] = '0;
    end
    for (int k = 0; k < KEY_POOL_SIZE; k++) begin
      key_pool[k] = $urandom;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      pace_sender();
      send_request(DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].proc,
                   DIRECTED_ROWS[r].has_typed, DIRECTED_ROWS[r].result);
    end
    // Let the engine empty out completely before the random traffic starts.
    wait_for_drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) begin
        wait_for_drain();
      end
      pace_sender();
      send_request(choose_key(n), 6'($urandom_range(0, 63)), 1'b0, '0);
    end

    wait_for_drain();
    // Anything that shows up during this tail is an unexpected result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side. Outputs are sampled at the edge where the handshake completes,
  // and ready follows one of several stall patterns that switch over time:
  // always ready, mostly ready, or mostly stalled.
  always @(posedge clk) begin
    lookup_result_t seen;
    lookup_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {success, slot_index, newly_created};
        if (expected_results.size() == 0) begin
          log_mismatch("result with none pending", '0, seen);
        end else begin
          want = expected_results.pop_front();
          if (seen.success !== want.success || seen.slot_index !== want.slot_index ||
              seen.newly_created !== want.newly_created) begin
            log_mismatch("result mismatch", want, seen);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d results still pending", expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

### semaphore_key_lookup_or_create_top.f
hdl/skl_pkg.sv
hdl/skl_ram.sv
hdl/skl_scan.sv
hdl/semaphore_key_lookup_or_create_top.sv
verif/semaphore_key_lookup_or_create_top_test.sv
